// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the metaball potential RTL.
// No dependencies; synthesis builds define SYNTHESIS and get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("invariant check failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`endif
`endif

// File: hw/rtl/mpe_pkg.sv
// Widths and register indexes for the metaball potential evaluator.
// No dependencies; imported by every module of the block.
package mpe_pkg;

    localparam int COORD_W    = 14;
    localparam int RAD_W      = 6;
    localparam int POT_W      = 18;
    localparam int D2_W       = 2 * COORD_W + 1;
    localparam int ROOT_W     = (D2_W + 1) / 2;
    localparam int RR_W       = 2 * RAD_W;
    localparam int R3_W       = 3 * RAD_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = COORD_W;

    localparam logic [POT_W-1:0] POT_MAX = {POT_W{1'b1}};
    localparam logic [RAD_W-1:0] RADIUS_RESET = RAD_W'(20);

    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 2'd2;

endpackage

// File: hw/rtl/mpe_sqrt_pipe.sv
// Pipelined integer square root, one result bit per register stage.
// Depends on mpe_pkg for the radicand and root widths.
module mpe_sqrt_pipe
    import mpe_pkg::*;
#(
    parameter int SIDE_W = 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [D2_W-1:0]   radicand,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [ROOT_W-1:0] root,
    output logic [SIDE_W-1:0] out_side
);

    localparam int REM_W = D2_W + 1;

    logic [ROOT_W-1:0] valid_reg;
    logic [D2_W-1:0]   rem_reg   [ROOT_W];
    logic [ROOT_W-1:0] root_reg  [ROOT_W];
    logic [SIDE_W-1:0] side_reg  [ROOT_W];
    logic [D2_W-1:0]   rem_in    [ROOT_W];
    logic [ROOT_W-1:0] root_in   [ROOT_W];
    logic [SIDE_W-1:0] side_in   [ROOT_W];
    logic [D2_W-1:0]   rem_next  [ROOT_W];
    logic [ROOT_W-1:0] root_next [ROOT_W];

    always_comb
    begin
        logic [REM_W-1:0] trial;
        logic [REM_W-1:0] rem_ext;
        rem_in[0]  = radicand;
        root_in[0] = '0;
        side_in[0] = in_side;
        for (int k = 1; k < ROOT_W; k++)
        begin
            rem_in[k]  = rem_reg[k-1];
            root_in[k] = root_reg[k-1];
            side_in[k] = side_reg[k-1];
        end
        for (int k = 0; k < ROOT_W; k++)
        begin
            trial   = (REM_W'(root_in[k]) << (ROOT_W - k))
                    | (REM_W'(1) << (2 * (ROOT_W - 1 - k)));
            rem_ext = REM_W'(rem_in[k]);
            if (rem_ext >= trial)
            begin
                rem_next[k]  = D2_W'(rem_ext - trial);
                root_next[k] = root_in[k] | (ROOT_W'(1) << (ROOT_W - 1 - k));
            end
            else
            begin
                rem_next[k]  = rem_in[k];
                root_next[k] = root_in[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[ROOT_W-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < ROOT_W; k++)
        begin
            rem_reg[k]  <= rem_next[k];
            root_reg[k] <= root_next[k];
            side_reg[k] <= side_in[k];
        end
    end

    assign out_valid = valid_reg[ROOT_W-1];
    assign root      = root_reg[ROOT_W-1];
    assign out_side  = side_reg[ROOT_W-1];

endmodule

// File: hw/rtl/mpe_div_pipe.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on mpe_pkg and on assert_macros.svh for its checks.
`include "assert_macros.svh"
module mpe_div_pipe
    import mpe_pkg::*;
#(
    parameter int NUM_W  = 27,
    parameter int DEN_W  = 15,
    parameter int SIDE_W = 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  numerator,
    input  logic [DEN_W-1:0]  denominator,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [NUM_W-1:0]  quotient,
    output logic [DEN_W-1:0]  den_out,
    output logic [SIDE_W-1:0] out_side
);

    localparam int CHK_W = NUM_W + DEN_W;

    logic [NUM_W-1:0]  valid_reg;
    logic [DEN_W-1:0]  rem_reg   [NUM_W];
    logic [NUM_W-1:0]  quot_reg  [NUM_W];
    logic [NUM_W-1:0]  num_reg   [NUM_W];
    logic [DEN_W-1:0]  den_reg   [NUM_W];
    logic [SIDE_W-1:0] side_reg  [NUM_W];
    logic [DEN_W-1:0]  rem_in    [NUM_W];
    logic [NUM_W-1:0]  quot_in   [NUM_W];
    logic [NUM_W-1:0]  num_in    [NUM_W];
    logic [DEN_W-1:0]  den_in    [NUM_W];
    logic [SIDE_W-1:0] side_in   [NUM_W];
    logic [DEN_W-1:0]  rem_next  [NUM_W];
    logic [NUM_W-1:0]  quot_next [NUM_W];

    always_comb
    begin
        logic [DEN_W:0] part;
        rem_in[0]  = '0;
        quot_in[0] = '0;
        num_in[0]  = numerator;
        den_in[0]  = denominator;
        side_in[0] = in_side;
        for (int k = 1; k < NUM_W; k++)
        begin
            rem_in[k]  = rem_reg[k-1];
            quot_in[k] = quot_reg[k-1];
            num_in[k]  = num_reg[k-1];
            den_in[k]  = den_reg[k-1];
            side_in[k] = side_reg[k-1];
        end
        for (int k = 0; k < NUM_W; k++)
        begin
            part = {rem_in[k], num_in[k][NUM_W-1-k]};
            if (part >= {1'b0, den_in[k]})
            begin
                rem_next[k]  = DEN_W'(part - {1'b0, den_in[k]});
                quot_next[k] = quot_in[k] | (NUM_W'(1) << (NUM_W - 1 - k));
            end
            else
            begin
                rem_next[k]  = part[DEN_W-1:0];
                quot_next[k] = quot_in[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[NUM_W-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NUM_W; k++)
        begin
            rem_reg[k]  <= rem_next[k];
            quot_reg[k] <= quot_next[k];
            num_reg[k]  <= num_in[k];
            den_reg[k]  <= den_in[k];
            side_reg[k] <= side_in[k];
        end
    end

    assign out_valid = valid_reg[NUM_W-1];
    assign quotient  = quot_reg[NUM_W-1];
    assign den_out   = den_reg[NUM_W-1];
    assign out_side  = side_reg[NUM_W-1];

    `ASSERT_IMPLY(a_div_exact, clk, rst_n, out_valid && den_out != '0, (CHK_W'(quotient) * CHK_W'(den_out) + CHK_W'(rem_reg[NUM_W-1])) == CHK_W'(num_reg[NUM_W-1]))
    `ASSERT_IMPLY(a_div_rem_small, clk, rst_n, out_valid && den_out != '0, rem_reg[NUM_W-1] < den_out)

endmodule

// File: hw/rtl/metaball_potential_eval.sv
// Top level of the metaball potential evaluator: distance, square root, divide.
// Depends on mpe_pkg, mpe_sqrt_pipe, mpe_div_pipe and assert_macros.svh.
//
//   Channel   Handshake            Payload
//   query     start / busy         query_x, query_y
//   config    wr_en                wr_index, wr_data
//   result    result_valid strobe  potential, inside_ball
//
// A query point is taken in every cycle; busy is always low.
// Each result passes from its beat through the front registers s1 to s4, the
// one-bit-per-stage square root and divider pipelines and the output register.
// Reset clears the valid bits and loads the ball defaults.
// The result side has no back pressure, so the pipeline never stalls.
`include "assert_macros.svh"
module metaball_potential_eval
    import mpe_pkg::*;
#(
    parameter int FRAC_BITS = 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [COORD_W-1:0]    query_x,
    input  logic [COORD_W-1:0]    query_y,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    output logic                  result_valid,
    output logic [POT_W-1:0]      potential,
    output logic                  inside_ball
);

    localparam int NUM_W  = R3_W + 1 + 2 * FRAC_BITS;
    localparam int EXT_W  = D2_W + 1 + 2 * FRAC_BITS;
    localparam int SIDE_W = POT_W + 1;
    localparam int LAT    = 5 + ROOT_W + NUM_W;

    logic [COORD_W-1:0] center_x_reg;
    logic [COORD_W-1:0] center_y_reg;
    logic [RAD_W-1:0]   radius_reg;

    logic                      s1_valid_reg;
    logic signed [COORD_W:0]   s1_dx_reg;
    logic signed [COORD_W:0]   s1_dy_reg;
    logic [RAD_W-1:0]          s1_r_reg;
    logic                      s2_valid_reg;
    logic [2*COORD_W-1:0]      s2_dx2_reg;
    logic [2*COORD_W-1:0]      s2_dy2_reg;
    logic [RR_W-1:0]           s2_rr_reg;
    logic [RAD_W-1:0]          s2_r_reg;
    logic                      s3_valid_reg;
    logic [D2_W-1:0]           s3_d2_reg;
    logic [RR_W-1:0]           s3_rr_reg;
    logic [R3_W-1:0]           s3_r3_reg;
    logic                      s4_valid_reg;
    logic [D2_W-1:0]           s4_d2_reg;
    logic [NUM_W-1:0]          s4_num_reg;
    logic [SIDE_W-1:0]         s4_side_reg;

    logic signed [2*COORD_W+1:0] dx_sq;
    logic signed [2*COORD_W+1:0] dy_sq;
    logic [EXT_W-1:0]  r2_ext;
    logic [EXT_W-1:0]  d2_ext;
    logic [EXT_W-1:0]  pin_ext;
    logic [POT_W-1:0]  pin_sat;
    logic              inside_next;

    logic                      sq_valid;
    logic [ROOT_W-1:0]         sq_root;
    logic [NUM_W+SIDE_W-1:0]   sq_side;
    logic                      dv_valid;
    logic [NUM_W-1:0]          dv_quot;
    logic [ROOT_W-1:0]         dv_den;
    logic [SIDE_W-1:0]         dv_side;

    logic              result_valid_reg;
    logic [POT_W-1:0]  potential_reg;
    logic              inside_reg;
    logic [POT_W-1:0]  potential_next;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            radius_reg   <= RADIUS_RESET;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                CFG_CENTER_X: center_x_reg <= wr_data[COORD_W-1:0];
                CFG_CENTER_Y: center_y_reg <= wr_data[COORD_W-1:0];
                CFG_RADIUS:   radius_reg   <= wr_data[RAD_W-1:0];
                default:      ;
            endcase
        end
    end

    assign dx_sq = s1_dx_reg * s1_dx_reg;
    assign dy_sq = s1_dy_reg * s1_dy_reg;

    always_comb
    begin
        r2_ext      = EXT_W'(s3_rr_reg) << (2 * FRAC_BITS);
        d2_ext      = EXT_W'(s3_d2_reg);
        inside_next = d2_ext < r2_ext;
        pin_ext     = ((r2_ext << 1) + r2_ext - d2_ext) >> FRAC_BITS;
        pin_sat     = (pin_ext > EXT_W'(POT_MAX)) ? POT_MAX : pin_ext[POT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            s3_valid_reg     <= 1'b0;
            s4_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg     <= start && !busy;
            s2_valid_reg     <= s1_valid_reg;
            s3_valid_reg     <= s2_valid_reg;
            s4_valid_reg     <= s3_valid_reg;
            result_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_dx_reg   <= $signed({1'b0, query_x}) - $signed({1'b0, center_x_reg});
        s1_dy_reg   <= $signed({1'b0, query_y}) - $signed({1'b0, center_y_reg});
        s1_r_reg    <= radius_reg;
        s2_dx2_reg  <= dx_sq[2*COORD_W-1:0];
        s2_dy2_reg  <= dy_sq[2*COORD_W-1:0];
        s2_rr_reg   <= RR_W'(s1_r_reg) * RR_W'(s1_r_reg);
        s2_r_reg    <= s1_r_reg;
        s3_d2_reg   <= D2_W'(s2_dx2_reg) + D2_W'(s2_dy2_reg);
        s3_rr_reg   <= s2_rr_reg;
        s3_r3_reg   <= R3_W'(s2_rr_reg) * R3_W'(s2_r_reg);
        s4_d2_reg   <= s3_d2_reg;
        s4_num_reg  <= NUM_W'(s3_r3_reg) << (2 * FRAC_BITS + 1);
        s4_side_reg <= {inside_next, pin_sat};
    end

    mpe_sqrt_pipe #(
        .SIDE_W (NUM_W + SIDE_W)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s4_valid_reg),
        .radicand  (s4_d2_reg),
        .in_side   ({s4_num_reg, s4_side_reg}),
        .out_valid (sq_valid),
        .root      (sq_root),
        .out_side  (sq_side)
    );

    mpe_div_pipe #(
        .NUM_W  (NUM_W),
        .DEN_W  (ROOT_W),
        .SIDE_W (SIDE_W)
    ) u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (sq_valid),
        .numerator   (sq_side[NUM_W+SIDE_W-1:SIDE_W]),
        .denominator (sq_root),
        .in_side     (sq_side[SIDE_W-1:0]),
        .out_valid   (dv_valid),
        .quotient    (dv_quot),
        .den_out     (dv_den),
        .out_side    (dv_side)
    );

    always_comb
    begin
        if (dv_side[POT_W])
        begin
            potential_next = dv_side[POT_W-1:0];
        end
        else if (dv_den == '0)
        begin
            potential_next = '0;
        end
        else if (dv_quot > NUM_W'(POT_MAX))
        begin
            potential_next = POT_MAX;
        end
        else
        begin
            potential_next = dv_quot[POT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        potential_reg <= potential_next;
        inside_reg    <= dv_side[POT_W];
    end

    assign result_valid = result_valid_reg;
    assign potential    = potential_reg;
    assign inside_ball  = inside_reg;

    `ASSERT_ALWAYS(a_result_latency, clk, rst_n, result_valid == $past(start && !busy && rst_n, LAT))
    `ASSERT_IMPLY(a_inside_nonzero, clk, rst_n, result_valid && inside_ball, potential != '0)

endmodule
